/* rtl/tlb_page_table_fifo_translator_core_macros.svh */
// assertion macros for the translator core
`ifndef TLB_PAGE_TABLE_FIFO_TRANSLATOR_CORE_MACROS_SVH
`define TLB_PAGE_TABLE_FIFO_TRANSLATOR_CORE_MACROS_SVH
// implication checked every clock outside reset
`define TPT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication checked outside reset
`define TPT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* rtl/tpt_pkg.sv */
// shared types for the translator core
package tpt_pkg;
  typedef struct packed {
    logic [15:0] addr;
  } tpt_req_t;
endpackage

/* rtl/tpt_ram.sv */
// generic ram with one write port and one read port, registered read
module tpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/tpt_front.sv */
// input stage and two-entry request queue
module tpt_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [15:0]       in_logical_address,
  output logic              q_valid,
  output tpt_pkg::tpt_req_t q_req,
  input  logic              q_pop
);
  import tpt_pkg::*;
  tpt_req_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic rd_r, wr_r;
  logic push;
  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt_r != 2'd0);
  assign q_req = q_r[rd_r];
  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= !wr_r;
      if (q_pop) rd_r <= !rd_r;
    end
    if (push) q_r[wr_r].addr <= in_logical_address;
  end
endmodule

/* rtl/tpt_back.sv */
// translation engine: tlb search, page table, frame replacement
module tpt_back #(
  parameter int TLB_ENTRIES = 16,
  parameter int NUM_FRAMES = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  tpt_pkg::tpt_req_t q_req,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [14:0]       out_physical_address,
  output logic              out_tlb_hit,
  output logic              out_page_fault,
  output logic              out_evict_valid,
  output logic [7:0]        out_evicted_page
);
  import tpt_pkg::*;
  localparam int TW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  typedef enum logic [2:0] {S_IDLE, S_LOOK, S_PT, S_OWN, S_DONE} state_t;
  state_t st_r;
  logic [TLB_ENTRIES-1:0] tv_r;
  logic [7:0] tt_r [TLB_ENTRIES];
  logic [FW-1:0] tf_r [TLB_ENTRIES];
  logic [TW-1:0] tn_r;
  logic [255:0] pv_r;
  logic [FW-1:0] nf_r;
  logic full_r;
  logic [7:0] page_r, off_r;
  logic [FW-1:0] frame_r;
  logic pt_we, fo_we;
  logic [7:0] pt_wa;
  logic [FW-1:0] pt_wd, pt_rd;
  logic [7:0] fo_rd;
  logic hit_c;
  logic [FW-1:0] hf_c;
  tpt_ram #(.WIDTH(FW), .DEPTH(256)) u_pt (
    .clk(clk), .we(pt_we), .waddr(pt_wa), .wdata(pt_wd),
    .raddr(st_r == S_IDLE ? q_req.addr[15:8] : page_r), .rdata(pt_rd));
  tpt_ram #(.WIDTH(8), .DEPTH(NUM_FRAMES)) u_fo (
    .clk(clk), .we(fo_we), .waddr(nf_r), .wdata(page_r),
    .raddr(nf_r), .rdata(fo_rd));
  always_comb begin
    hit_c = 1'b0;
    hf_c = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if (!hit_c && tv_r[i] && tt_r[i] == page_r) begin
        hit_c = 1'b1;
        hf_c = tf_r[i];
      end
    end
  end
  assign pt_we = (st_r == S_OWN);
  assign pt_wa = page_r;
  assign pt_wd = nf_r;
  assign fo_we = (st_r == S_OWN);
  assign q_pop = (st_r == S_IDLE) && q_valid && !out_valid;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      tv_r <= '0;
      tn_r <= '0;
      pv_r <= '0;
      nf_r <= '0;
      full_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (q_pop) begin
            page_r <= q_req.addr[15:8];
            off_r <= q_req.addr[7:0];
            st_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          out_page_fault <= 1'b0;
          out_evict_valid <= 1'b0;
          out_evicted_page <= '0;
          if (hit_c) begin
            out_tlb_hit <= 1'b1;
            out_physical_address <= 15'({hf_c, off_r});
            out_valid <= 1'b1;
            st_r <= S_IDLE;
          end else begin
            out_tlb_hit <= 1'b0;
            st_r <= pv_r[page_r] ? S_PT : S_OWN;
          end
        end
        S_PT: begin
          frame_r <= pt_rd;
          st_r <= S_DONE;
        end
        S_OWN: begin
          out_page_fault <= 1'b1;
          frame_r <= nf_r;
          if (full_r && pv_r[fo_rd]) begin
            pv_r[fo_rd] <= 1'b0;
            out_evict_valid <= 1'b1;
            out_evicted_page <= fo_rd;
            for (int i = 0; i < TLB_ENTRIES; i++)
              if (tt_r[i] == fo_rd) tv_r[i] <= 1'b0;
          end
          pv_r[page_r] <= 1'b1;
          if (nf_r == FW'(NUM_FRAMES - 1)) begin
            nf_r <= '0;
            full_r <= 1'b1;
          end else begin
            nf_r <= nf_r + 1'b1;
          end
          st_r <= S_DONE;
        end
        S_DONE: begin
          tv_r[tn_r] <= 1'b1;
          tt_r[tn_r] <= page_r;
          tf_r[tn_r] <= frame_r;
          tn_r <= (tn_r == TW'(TLB_ENTRIES - 1)) ? '0 : tn_r + 1'b1;
          out_physical_address <= 15'({frame_r, off_r});
          out_valid <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
`include "tlb_page_table_fifo_translator_core_macros.svh"
  `TPT_ASSERT_IMP(a_pop_idle, q_pop, st_r == S_IDLE && !out_valid, "pop while busy")
  `TPT_ASSERT_NXT(a_own_done, st_r == S_OWN, st_r == S_DONE, "fault path broke")
  `TPT_ASSERT_IMP(a_ev_fault, out_valid && out_evict_valid, out_page_fault, "evict w/o fault")
endmodule

/* rtl/tlb_page_table_fifo_translator_core.sv */
// top level of the translator core
// sequenced by the back end: a tlb hit goes from accept through lookup to the
// result; a miss adds a page-table read or a frame allocation, then a tlb fill
// (page-table and frame-owner ram reads are registered); one request at a time
// reset: synchronous active-low, clears tlb and page valid bits, fifo pointers
module tlb_page_table_fifo_translator_core #(
  parameter int TLB_ENTRIES = 16,
  parameter int NUM_FRAMES = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_logical_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [14:0] out_physical_address,
  output logic        out_tlb_hit,
  output logic        out_page_fault,
  output logic        out_evict_valid,
  output logic [7:0]  out_evicted_page
);
  import tpt_pkg::*;
  logic q_valid, q_pop;
  tpt_req_t q_req;
  tpt_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_logical_address(in_logical_address), .q_valid(q_valid), .q_req(q_req),
    .q_pop(q_pop));
  tpt_back #(.TLB_ENTRIES(TLB_ENTRIES), .NUM_FRAMES(NUM_FRAMES)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_req(q_req), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_physical_address(out_physical_address), .out_tlb_hit(out_tlb_hit),
    .out_page_fault(out_page_fault), .out_evict_valid(out_evict_valid),
    .out_evicted_page(out_evicted_page));
endmodule
